FILE: rtl/binary_min_heap_macros.svh
// binary_min_heap_macros.svh: assertion macros for the min-heap checker
// no dependencies; included by the checker file
`ifndef BINARY_MIN_HEAP_MACROS_SVH
`define BINARY_MIN_HEAP_MACROS_SVH

// same-cycle implication, held off during reset
`define BMH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("binary_min_heap: same-cycle check failed");

// next-cycle implication, held off during reset
`define BMH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("binary_min_heap: next-cycle check failed");

`endif

FILE: rtl/bmh_pkg.sv
// bmh_pkg: constants, codes, command type and helpers of the min-heap
// no dependencies; used by every other rtl file but the macro header
`default_nettype none

package bmh_pkg;

  // heap size and derived widths
  localparam int CAPACITY    = 64;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // item and result field widths
  localparam int KIND_W      = 1;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;

  // command queue between front and engine, a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // kind codes of an input item
  localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 1'b1;

  // work for the engine
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SKIP   = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // classified command, count is the entry count after the item
  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
    status_t                    status;
    logic [CNT_W-1:0]           count;
  } cmd_t;

  // count as shown on the result port, masked or zero-extended
  function automatic logic [COUNT_OUT_W-1:0] to_count_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_OUT_W-1:0] w;
    w = {{COUNT_OUT_W{1'b0}}, c};
    return w[COUNT_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bmh_if.sv
// bmh_req_if, bmh_rsp_if: valid/ready channels for items and results
// depends on bmh_pkg
`default_nettype none

interface bmh_req_if import bmh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface bmh_rsp_if import bmh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] removed_value;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_OUT_W-1:0]    count_after;
  logic                      is_empty;
  logic                      is_full;

  modport source (output valid, removed_value, status, count_after, is_empty, is_full,
                  input ready);
  modport sink   (input valid, removed_value, status, count_after, is_empty, is_full,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/binary_min_heap.sv
// binary_min_heap: top level of the min-heap priority queue
// depends on bmh_pkg, bmh_if, bmh_front, bmh_queue, bmh_engine
//
// Min-heap of signed 32-bit values, CAPACITY entries deep. An insert item
// (kind 0) adds its value, a remove item (kind 1) returns the smallest held
// value; each item gives one result with status, the count after the item
// and empty/full flags. Remove on an empty heap and insert on a full heap
// change nothing and report status 1 or 2. The front stage classifies items
// at once and queues them, so the input is taken while the engine works and
// while a result waits on the output, as long as the queue has room. The
// engine handles one item at a time and moves one tree level per cycle
// through the single write port of the heap store: an insert climbs until its
// parent is not larger, a remove sinks until no child is smaller, and a
// refused item goes straight to its result. No clearing pass after reset.
`default_nettype none

module binary_min_heap import bmh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bmh_req_if.sink   req,
  bmh_rsp_if.source rsp
);

  cmd_t q_in, q_head;
  logic q_push, q_full, q_valid, q_pop;

  bmh_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in)
  );

  bmh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  bmh_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/bmh_front.sv
// bmh_front: accepts items, tracks the entry count ahead of the engine and
// classifies each item into a command; depends on bmh_pkg, bmh_if
`default_nettype none

module bmh_front import bmh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bmh_req_if.sink    req,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             at_full;
  logic             at_empty;

  assign req.ready = !q_full;
  assign q_push    = req.valid && req.ready;
  assign at_full   = (count == CNT_W'(CAPACITY));
  assign at_empty  = (count == '0);

  // classify the item against the count it will meet
  always_comb begin
    count_next   = count;
    q_cmd.value  = req.value;
    q_cmd.op     = OP_SKIP;
    q_cmd.status = ST_OK;
    if (req.kind == KIND_REMOVE) begin
      if (at_empty) begin
        q_cmd.status = ST_EMPTY;
      end else begin
        q_cmd.op   = OP_REMOVE;
        count_next = count - CNT_W'(1);
      end
    end else begin
      if (at_full) begin
        q_cmd.status = ST_FULL;
      end else begin
        q_cmd.op   = OP_INSERT;
        count_next = count + CNT_W'(1);
      end
    end
    q_cmd.count = count_next;
  end

  // count moves when an item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (q_push) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bmh_queue.sv
// bmh_queue: short command queue between the front and the engine
// depends on bmh_pkg
`default_nettype none

module bmh_queue import bmh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bmh_engine.sv
// bmh_engine: heap store and sift sequencer, one tree level per cycle,
// with the result register; depends on bmh_pkg, bmh_if
`default_nettype none

module bmh_engine import bmh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  bmh_rsp_if.source rsp
);

  localparam int DW = IDX_W + 2;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_START   = 7'b0000010,
    S_UP      = 7'b0000100,
    S_PUT     = 7'b0001000,
    S_DN_LOAD = 7'b0010000,
    S_DOWN    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t                    state, state_next;
  cmd_t                      cur, cur_next;
  logic [IDX_W-1:0]          pos, pos_next;
  logic signed [VALUE_W-1:0] hold, hold_next;
  logic signed [VALUE_W-1:0] removed, removed_next;

  // heap store, one write port and two registered read ports
  logic signed [VALUE_W-1:0] mem [CAPACITY];
  logic signed [VALUE_W-1:0] rd_a, rd_b;
  logic [IDX_W-1:0]          ra, rb, wa;
  logic signed [VALUE_W-1:0] wd;
  logic                      we;

  // result register
  logic                      res_valid;
  logic                      res_load;
  logic signed [VALUE_W-1:0] res_removed;
  logic [STATUS_W-1:0]       res_status;
  logic [COUNT_OUT_W-1:0]    res_count;
  logic                      res_empty;
  logic                      res_full;

  // index arithmetic
  logic [IDX_W-1:0]  ins_pos;
  logic [IDX_W-1:0]  parent;
  logic [IDX_W-1:0]  grand;
  logic [DW-1:0]     left_w, right_w, cnt_w;
  logic              has_left, has_right;
  logic              take_left, take_right, move_down;
  logic signed [VALUE_W-1:0] best_val;
  logic [IDX_W-1:0]  child;
  logic [IDX_W:0]    child_l;

  assign ins_pos    = IDX_W'(cur.count - CNT_W'(1));
  assign parent     = (pos - IDX_W'(1)) >> 1;
  assign grand      = (parent - IDX_W'(1)) >> 1;
  assign left_w     = {1'b0, pos, 1'b1};
  assign right_w    = left_w + DW'(1);
  assign cnt_w      = DW'(cur.count);
  assign has_left   = (left_w < cnt_w);
  assign has_right  = (right_w < cnt_w);

  // smallest of hold, left child, right child; ties keep the earlier one
  assign take_left  = (rd_a < hold);
  assign best_val   = take_left ? rd_a : hold;
  assign take_right = has_right && (rd_b < best_val);
  assign move_down  = has_left && (take_left || take_right);
  assign child      = take_right ? IDX_W'(right_w) : IDX_W'(left_w);
  assign child_l    = {child, 1'b1};

  // sequencer
  always_comb begin
    state_next   = state;
    cur_next     = cur;
    pos_next     = pos;
    hold_next    = hold;
    removed_next = removed;
    cmd_pop      = 1'b0;
    res_load     = 1'b0;
    we           = 1'b0;
    wa           = pos;
    wd           = hold;
    ra           = parent;
    rb           = parent;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          cur_next   = cmd;
          hold_next  = cmd.value;
          state_next = S_START;
        end
      end
      S_START: begin
        case (cur.op)
          OP_INSERT: begin
            pos_next = ins_pos;
            if (ins_pos == '0) begin
              we         = 1'b1;
              wa         = '0;
              state_next = S_DONE;
            end else begin
              ra         = (ins_pos - IDX_W'(1)) >> 1;
              state_next = S_UP;
            end
          end
          OP_REMOVE: begin
            ra         = '0;
            rb         = IDX_W'(cur.count);
            state_next = S_DN_LOAD;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_UP: begin
        // move the parent down into the hole while the new value is smaller
        we = 1'b1;
        if (hold < rd_a) begin
          wd       = rd_a;
          pos_next = parent;
          ra       = grand;
          if (parent == '0) begin
            state_next = S_PUT;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_PUT: begin
        we         = 1'b1;
        state_next = S_DONE;
      end
      S_DN_LOAD: begin
        // root leaves, last entry becomes the value to sink from the root
        removed_next = rd_a;
        hold_next    = rd_b;
        pos_next     = '0;
        ra           = IDX_W'(1);
        rb           = IDX_W'(2);
        if (cur.count == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DOWN;
        end
      end
      S_DOWN: begin
        we = 1'b1;
        if (move_down) begin
          wd       = take_right ? rd_b : rd_a;
          pos_next = child;
          ra       = IDX_W'(child_l);
          rb       = IDX_W'(child_l + (IDX_W+1)'(1));
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid || rsp.ready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    cur     <= cur_next;
    pos     <= pos_next;
    hold    <= hold_next;
    removed <= removed_next;
    if (res_load) begin
      res_removed <= (cur.op == OP_REMOVE) ? removed : '0;
      res_status  <= cur.status;
      res_count   <= to_count_out(cur.count);
      res_empty   <= (cur.count == '0);
      res_full    <= (cur.count == CNT_W'(CAPACITY));
    end
  end

  // heap store access
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  assign rsp.valid         = res_valid;
  assign rsp.removed_value = res_removed;
  assign rsp.status        = res_status;
  assign rsp.count_after   = res_count;
  assign rsp.is_empty      = res_empty;
  assign rsp.is_full       = res_full;

endmodule

`default_nettype wire

FILE: rtl/bmh_checker.sv
// bmh_checker: port-level assertions on the min-heap results, bound to the top
// depends on bmh_pkg and binary_min_heap_macros.svh
`default_nettype none
`include "binary_min_heap_macros.svh"

module bmh_checker import bmh_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic signed [VALUE_W-1:0] removed_value,
  input logic [STATUS_W-1:0]       status,
  input logic [COUNT_OUT_W-1:0]    count_after,
  input logic                      is_empty,
  input logic                      is_full
);

  // a waiting result holds its value
  `BMH_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(removed_value))

  // a refused remove only happens on an empty heap and returns nothing
  `BMH_ASSERT_IMP(a_empty_refused, clk, rst, rsp_valid && status == ST_EMPTY, is_empty && removed_value == '0)

  // a refused insert only happens on a full heap and returns nothing
  `BMH_ASSERT_IMP(a_full_refused, clk, rst, rsp_valid && status == ST_FULL, is_full && !is_empty && removed_value == '0)

  // an empty heap shows a zero count and is never full
  `BMH_ASSERT_IMP(a_empty_count, clk, rst, rsp_valid && is_empty, count_after == '0 && !is_full)

endmodule

bind binary_min_heap bmh_checker u_bmh_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .removed_value (rsp.removed_value),
  .status        (rsp.status),
  .count_after   (rsp.count_after),
  .is_empty      (rsp.is_empty),
  .is_full       (rsp.is_full)
);

`default_nettype wire
